// ===== rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersection core
// Field widths, wide-word widths of the Moller-Trumbore datapath, register
// indexes of the configuration channel and the beat structs.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int CRD_W  = 21;   // Q11.10 coordinates, Q2.19 normals
    localparam int TEX_W  = 16;   // Q4.12 texture coordinates
    localparam int EDG_W  = 22;   // edge and origin-offset vectors
    localparam int WIDE_W = 70;   // det, nu, nv, nt (signed)
    localparam int MAG_W  = 69;   // magnitude of the above after sign fix
    localparam int QUO_W  = 31;   // quotient bits out of every divider
    localparam int DST_W  = 32;   // Q16.16 distance

    localparam logic signed [DST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] REG_VA_POS = 3'd0;
    localparam logic [2:0] REG_VB_POS = 3'd1;
    localparam logic [2:0] REG_VC_POS = 3'd2;
    localparam logic [2:0] REG_VA_NRM = 3'd3;
    localparam logic [2:0] REG_VB_NRM = 3'd4;
    localparam logic [2:0] REG_VC_NRM = 3'd5;
    localparam logic [2:0] REG_TC_AB  = 3'd6;
    localparam logic [2:0] REG_TC_C   = 3'd7;

    typedef struct packed {
        logic [31:0]            t_max;
        logic [31:0]            t_min;
        logic [2:0][CRD_W-1:0]  dir;
        logic [2:0][CRD_W-1:0]  org;
    } ray_t;

    // ray plus the per-ray decisions carried alongside the dividers
    typedef struct packed {
        logic [4:0] neg;      // sign of each interpolation numerator
        logic       sat;      // distance quotient overflows
        logic       ok;       // determinant, barycentric and t > 0 tests pass
        ray_t       ray;
    } carry_t;

    typedef struct packed {
        logic [2:0][CRD_W-1:0]  pnt;
        logic [2:0][CRD_W-1:0]  nrm;
        logic [TEX_W-1:0]       tex_v;
        logic [TEX_W-1:0]       tex_u;
        logic [DST_W-1:0]       distance;
        logic                   hit;
    } result_t;

endpackage

// ===== rtl/rti_div.sv =====
// ----------------------------------------------------------------------------
// rti_div: pipelined restoring divider
// One quotient bit per stage, MSB first. The caller guarantees
// num < den * 2^QB; the quotient then comes out exact after QB stages.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int NW = 90
) (
    input  logic                     aclk,
    input  logic                     ce,
    input  logic [NW-1:0]            num,
    input  logic [rti_pkg::MAG_W-1:0] den,
    output logic [rti_pkg::QUO_W-1:0] quo
);

    localparam int DW = rti_pkg::MAG_W;
    localparam int QB = rti_pkg::QUO_W;
    localparam int XW = (NW > DW + QB) ? NW : DW + QB;

    logic [NW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int K = QB - 1 - g;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quo_in;
        logic [XW-1:0] cand;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign cand = XW'(den_in) << K;
        assign ge   = XW'(rem_in) >= cand;

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g] <= ge ? NW'(XW'(rem_in) - cand) : rem_in;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_in | (QB'(ge) << K);
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

// ===== rtl/ray_triangle_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core: fixed-point Moller-Trumbore ray/triangle test
// Tests a stream of rays against one triangle held in registers and returns
// distance, interpolated texture coordinates, normal and hit point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write the triangle (positions, normals, texcoords) by index while
//            no ray is in flight. A write reaches rays only once the registered
//            vertex and edge values (a_reg, e1_reg, e2_reg) have taken it up.
//   s_*    : one ray per beat (origin, direction, open interval t_min..t_max).
//   m_*    : one result per ray, in order; m_tuser is the hit flag, and on a
//            miss every data field is zero.
// Throughput: one ray per cycle while the result channel keeps up, set by the fully pipelined
//   datapath (cross/dot products, five interpolation dividers and the
//   distance divider, all one quotient bit per stage).
// Pipeline: a ray passes 11 stages of products and tests, 31 divider stages,
//   2 output stages (p1, res_reg) and then the m_* output register.
// Reset: clears the triangle registers and empties the pipeline.
// Stall: the pipeline runs while the skid register is empty; after m_tready drops it
//   takes beats until a result fills the skid, then s_tready falls until m_* accepts a beat.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core #(
    parameter int DIST_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_data,
    // ray channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // t_min, t_max, 2 pad bits
    input  logic [191:0] s_tdata,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance, tex_u, tex_v, normal_x, normal_y, normal_z,
    // point_x, point_y, point_z, 2 pad bits
    output logic [191:0] m_tdata,
    // hit
    output logic         m_tuser
);

    localparam int CW    = rti_pkg::CRD_W;
    localparam int EW    = rti_pkg::EDG_W;
    localparam int WW    = rti_pkg::WIDE_W;
    localparam int MW    = rti_pkg::MAG_W;
    localparam int QB    = rti_pkg::QUO_W;
    localparam int NPRE  = 11;                       // stages before dividers
    localparam int NSTG  = NPRE + QB + 2;
    localparam int NW_I  = MW + CW;                  // interpolation numerator
    localparam int NW_T  = MW + DIST_FRAC_BITS;      // distance numerator
    localparam int SAT_W = MW + QB;
    localparam int PP_W  = 45;                       // 24b chunk x 21b attr
    localparam int TRM_W = 92;
    localparam int SUM_W = 94;
    localparam int PR_W  = rti_pkg::DST_W + CW;      // tf * dir
    localparam logic signed [PR_W-1:0] PT_RND =
        PR_W'((64'd1 << DIST_FRAC_BITS) - 64'd1);
    localparam logic signed [PR_W:0] PT_LO = -((PR_W+1)'(1) <<< (CW-1));
    localparam logic signed [PR_W:0] PT_HI = ((PR_W+1)'(1) <<< (CW-1)) - 1;

    // ---------------- configuration registers ----------------
    logic [62:0] pos_reg [3];
    logic [62:0] nrm_reg [3];
    logic [63:0] tab_reg;
    logic [31:0] tc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                nrm_reg[i] <= '0;
            end
            tab_reg <= '0;
            tc_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                rti_pkg::REG_VA_POS: pos_reg[0] <= cfg_data[62:0];
                rti_pkg::REG_VB_POS: pos_reg[1] <= cfg_data[62:0];
                rti_pkg::REG_VC_POS: pos_reg[2] <= cfg_data[62:0];
                rti_pkg::REG_VA_NRM: nrm_reg[0] <= cfg_data[62:0];
                rti_pkg::REG_VB_NRM: nrm_reg[1] <= cfg_data[62:0];
                rti_pkg::REG_VC_NRM: nrm_reg[2] <= cfg_data[62:0];
                rti_pkg::REG_TC_AB:  tab_reg    <= cfg_data;
                rti_pkg::REG_TC_C:   tc_reg     <= cfg_data[31:0];
            endcase
        end
    end

    // triangle-derived constants, refreshed every cycle
    logic signed [CW-1:0] a_reg  [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [CW-1:0] attr   [5][3];   // tex u, tex v, normal x/y/z per vertex

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            a_reg[i]  <= pos_reg[0][CW*i +: CW];
            e1_reg[i] <= $signed(pos_reg[1][CW*i +: CW]) - $signed(pos_reg[0][CW*i +: CW]);
            e2_reg[i] <= $signed(pos_reg[2][CW*i +: CW]) - $signed(pos_reg[0][CW*i +: CW]);
        end
    end

    always_comb begin
        attr[0][0] = CW'($signed(tab_reg[15:0]));
        attr[0][1] = CW'($signed(tab_reg[47:32]));
        attr[0][2] = CW'($signed(tc_reg[15:0]));
        attr[1][0] = CW'($signed(tab_reg[31:16]));
        attr[1][1] = CW'($signed(tab_reg[63:48]));
        attr[1][2] = CW'($signed(tc_reg[31:16]));
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                attr[2+k][j] = nrm_reg[j][CW*k +: CW];
            end
        end
    end

    // ---------------- flow control ----------------
    logic               ce;
    logic [NSTG-1:0]    vld_reg;
    logic               m_tvalid_reg;
    logic               skid_valid_reg;
    rti_pkg::result_t   res_reg;      // last pipeline stage
    rti_pkg::result_t   skid_reg;
    rti_pkg::result_t   out_reg;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // ---------------- input unpack ----------------
    rti_pkg::ray_t       in_ray;
    logic signed [CW-1:0] in_org [3];
    logic signed [CW-1:0] in_dir [3];

    assign in_ray.org   = s_tdata[62:0];
    assign in_ray.dir   = s_tdata[125:63];
    assign in_ray.t_min = s_tdata[157:126];
    assign in_ray.t_max = s_tdata[189:158];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_org[i] = in_ray.org[i];
            in_dir[i] = in_ray.dir[i];
        end
    end

    rti_pkg::ray_t rayp_reg [NPRE];

    always_ff @(posedge aclk) begin
        if (ce) begin
            rayp_reg[0] <= in_ray;
            for (int i = 1; i < NPRE; i++) rayp_reg[i] <= rayp_reg[i-1];
        end
    end

    // ---------------- stages 1..5: cross and dot products ----------------
    logic signed [EW-1:0]  s1_s_reg   [3];
    logic signed [42:0]    s1_hp0_reg [3];
    logic signed [42:0]    s1_hp1_reg [3];
    logic signed [43:0]    s2_h_reg   [3];
    logic signed [EW-1:0]  s2_s_reg   [3];
    logic signed [43:0]    s2_qp0_reg [3];
    logic signed [43:0]    s2_qp1_reg [3];
    logic signed [44:0]    s3_q_reg   [3];
    logic signed [44:0]    s3_dlo_reg [3];
    logic signed [43:0]    s3_dhi_reg [3];
    logic signed [44:0]    s3_ulo_reg [3];
    logic signed [43:0]    s3_uhi_reg [3];
    logic signed [44:0]    s4_vlo_reg [3];
    logic signed [42:0]    s4_vhi_reg [3];
    logic signed [45:0]    s4_tlo_reg [3];
    logic signed [43:0]    s4_thi_reg [3];
    logic signed [WW-1:0]  s4_det_reg, s4_nu_reg;
    logic signed [WW-1:0]  s5_det_reg, s5_nu_reg, s5_nv_reg, s5_nt_reg;
    logic signed [22:0]    h_lo [3];
    logic signed [21:0]    h_hi [3];
    logic signed [23:0]    q_lo [3];
    logic signed [21:0]    q_hi [3];

    for (genvar g = 0; g < 3; g++) begin : g_vec
        localparam int J1 = (g + 1) % 3;
        localparam int J2 = (g + 2) % 3;

        assign h_lo[g] = $signed({1'b0, s2_h_reg[g][21:0]});
        assign h_hi[g] = s2_h_reg[g][43:22];
        assign q_lo[g] = $signed({1'b0, s3_q_reg[g][22:0]});
        assign q_hi[g] = s3_q_reg[g][44:23];

        always_ff @(posedge aclk) begin
            if (ce) begin
                // H = D x E2
                s1_s_reg[g]   <= in_org[g] - a_reg[g];
                s1_hp0_reg[g] <= in_dir[J1] * e2_reg[J2];
                s1_hp1_reg[g] <= in_dir[J2] * e2_reg[J1];
                // Q = S x E1
                s2_h_reg[g]   <= s1_hp0_reg[g] - s1_hp1_reg[g];
                s2_s_reg[g]   <= s1_s_reg[g];
                s2_qp0_reg[g] <= s1_s_reg[J1] * e1_reg[J2];
                s2_qp1_reg[g] <= s1_s_reg[J2] * e1_reg[J1];
                // 44b H split in halves for det and nu
                s3_q_reg[g]   <= s2_qp0_reg[g] - s2_qp1_reg[g];
                s3_dlo_reg[g] <= e1_reg[g] * h_lo[g];
                s3_dhi_reg[g] <= e1_reg[g] * h_hi[g];
                s3_ulo_reg[g] <= s2_s_reg[g] * h_lo[g];
                s3_uhi_reg[g] <= s2_s_reg[g] * h_hi[g];
                // 45b Q split for nv and nt
                s4_vlo_reg[g] <= $signed(rayp_reg[2].dir[g]) * q_lo[g];
                s4_vhi_reg[g] <= $signed(rayp_reg[2].dir[g]) * q_hi[g];
                s4_tlo_reg[g] <= e2_reg[g] * q_lo[g];
                s4_thi_reg[g] <= e2_reg[g] * q_hi[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_det_reg <= (s3_dhi_reg[0] <<< 22) + s3_dlo_reg[0]
                        + (s3_dhi_reg[1] <<< 22) + s3_dlo_reg[1]
                        + (s3_dhi_reg[2] <<< 22) + s3_dlo_reg[2];
            s4_nu_reg  <= (s3_uhi_reg[0] <<< 22) + s3_ulo_reg[0]
                        + (s3_uhi_reg[1] <<< 22) + s3_ulo_reg[1]
                        + (s3_uhi_reg[2] <<< 22) + s3_ulo_reg[2];
            s5_det_reg <= s4_det_reg;
            s5_nu_reg  <= s4_nu_reg;
            s5_nv_reg  <= (s4_vhi_reg[0] <<< 23) + s4_vlo_reg[0]
                        + (s4_vhi_reg[1] <<< 23) + s4_vlo_reg[1]
                        + (s4_vhi_reg[2] <<< 23) + s4_vlo_reg[2];
            s5_nt_reg  <= (s4_thi_reg[0] <<< 23) + s4_tlo_reg[0]
                        + (s4_thi_reg[1] <<< 23) + s4_tlo_reg[1]
                        + (s4_thi_reg[2] <<< 23) + s4_tlo_reg[2];
        end
    end

    // ---------------- stages 6..7: sign fix and rejects ----------------
    logic signed [WW-1:0] s6_det_reg, s6_nu_reg, s6_nv_reg, s6_nt_reg;
    logic signed [WW-1:0] s7_det_reg, s7_nt_reg;
    logic signed [WW-1:0] s7_bary_reg [3];   // w', nu, nv
    logic                 s7_ok_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (s5_det_reg[WW-1]) begin
                s6_det_reg <= -s5_det_reg;
                s6_nu_reg  <= -s5_nu_reg;
                s6_nv_reg  <= -s5_nv_reg;
                s6_nt_reg  <= -s5_nt_reg;
            end else begin
                s6_det_reg <= s5_det_reg;
                s6_nu_reg  <= s5_nu_reg;
                s6_nv_reg  <= s5_nv_reg;
                s6_nt_reg  <= s5_nt_reg;
            end
            s7_ok_reg <= (s6_det_reg != '0)
                      && !s6_nu_reg[WW-1] && !(s6_nu_reg > s6_det_reg)
                      && !s6_nv_reg[WW-1] && !((s6_nu_reg + s6_nv_reg) > s6_det_reg)
                      && (s6_nt_reg > 0);
            s7_bary_reg[0] <= s6_det_reg - s6_nu_reg - s6_nv_reg;
            s7_bary_reg[1] <= s6_nu_reg;
            s7_bary_reg[2] <= s6_nv_reg;
            s7_det_reg     <= s6_det_reg;
            s7_nt_reg      <= s6_nt_reg;
        end
    end

    // ---------------- stages 8..11: interpolation numerators ----------------
    logic signed [PP_W-1:0]  s8_pp_reg   [5][3][3];
    logic signed [TRM_W-1:0] s9_trm_reg  [5][3];
    logic signed [SUM_W-1:0] s10_sum_reg [5];
    logic [NW_I-1:0]         s11_mag_reg [5];
    logic [4:0]              s11_neg_reg;
    logic [NW_T-1:0]         dnum_reg    [4];   // stages 8..11
    logic [MW-1:0]           dden_reg    [4];
    logic [3:0]              sat_reg;
    logic [3:0]              ok_reg;            // stages 8..11

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 5; k++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int c = 0; c < 3; c++) begin
                        s8_pp_reg[k][j][c] <=
                            $signed({1'b0, s7_bary_reg[j][23*c +: 23]}) * attr[k][j];
                    end
                    s9_trm_reg[k][j] <= s8_pp_reg[k][j][0]
                                      + (s8_pp_reg[k][j][1] <<< 23)
                                      + (s8_pp_reg[k][j][2] <<< 46);
                end
                s10_sum_reg[k] <= s9_trm_reg[k][0] + s9_trm_reg[k][1] + s9_trm_reg[k][2];
                s11_neg_reg[k] <= s10_sum_reg[k][SUM_W-1];
                s11_mag_reg[k] <= s10_sum_reg[k][SUM_W-1] ? NW_I'(-s10_sum_reg[k])
                                                          : NW_I'(s10_sum_reg[k]);
            end
            // distance: nt * 2^F / det, overflow when it needs more than QB bits
            sat_reg[0]  <= (SAT_W'(s7_nt_reg[MW-1:0]) << DIST_FRAC_BITS)
                        >= (SAT_W'(s7_det_reg[MW-1:0]) << QB);
            dnum_reg[0] <= NW_T'(s7_nt_reg[MW-1:0]) << DIST_FRAC_BITS;
            dden_reg[0] <= s7_det_reg[MW-1:0];
            ok_reg[0]   <= s7_ok_reg;
            for (int i = 1; i < 4; i++) begin
                sat_reg[i]  <= sat_reg[i-1];
                dnum_reg[i] <= dnum_reg[i-1];
                dden_reg[i] <= dden_reg[i-1];
                ok_reg[i]   <= ok_reg[i-1];
            end
        end
    end

    // ---------------- dividers ----------------
    logic [QB-1:0] itp_q [5];
    logic [QB-1:0] dist_q;

    for (genvar k = 0; k < 5; k++) begin : g_itp
        rti_div #(.NW(NW_I)) u_div (
            .aclk (aclk),
            .ce   (ce),
            .num  (s11_mag_reg[k]),
            .den  (dden_reg[3]),
            .quo  (itp_q[k])
        );
    end

    rti_div #(.NW(NW_T)) u_div_dist (
        .aclk (aclk),
        .ce   (ce),
        .num  (dnum_reg[3]),
        .den  (dden_reg[3]),
        .quo  (dist_q)
    );

    rti_pkg::carry_t dly_reg [QB];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0].ray <= rayp_reg[NPRE-1];
            dly_reg[0].ok  <= ok_reg[3];
            dly_reg[0].sat <= sat_reg[3];
            dly_reg[0].neg <= s11_neg_reg;
            for (int i = 1; i < QB; i++) dly_reg[i] <= dly_reg[i-1];
        end
    end

    // ---------------- output stages ----------------
    rti_pkg::carry_t                   dq;
    logic signed [rti_pkg::DST_W-1:0]  tf_next;
    logic signed [rti_pkg::DST_W-1:0]  p1_tf_reg;
    logic                              p1_hit_reg;
    logic signed [PR_W-1:0]            p1_prod_reg [3];
    logic [CW-1:0]                     p1_itp_reg  [5];
    logic [2:0][CW-1:0]                p1_org_reg;
    logic signed [PR_W-1:0]            pq      [3];
    logic signed [PR_W:0]              pt      [3];
    rti_pkg::result_t                  res_next;

    assign dq      = dly_reg[QB-1];
    assign tf_next = dq.sat ? rti_pkg::DIST_MAX : $signed({1'b0, dist_q});

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_tf_reg  <= tf_next;
            p1_hit_reg <= dq.ok && (tf_next > 0)
                       && (tf_next > $signed(dq.ray.t_min))
                       && (tf_next < $signed(dq.ray.t_max));
            for (int i = 0; i < 3; i++) begin
                p1_prod_reg[i] <= tf_next * $signed(dq.ray.dir[i]);
            end
            // weights sum to det, so each quotient fits its field
            for (int k = 0; k < 5; k++) begin
                p1_itp_reg[k] <= dq.neg[k] ? CW'(-itp_q[k][CW-1:0]) : itp_q[k][CW-1:0];
            end
            p1_org_reg <= dq.ray.org;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // truncate toward zero
            pq[i] = (p1_prod_reg[i] + (p1_prod_reg[i][PR_W-1] ? PT_RND : PR_W'(0)))
                    >>> DIST_FRAC_BITS;
            pt[i] = $signed(p1_org_reg[i]) + pq[i];
        end
        res_next = '0;
        if (p1_hit_reg) begin
            res_next.hit      = 1'b1;
            res_next.distance = p1_tf_reg;
            res_next.tex_u    = p1_itp_reg[0][rti_pkg::TEX_W-1:0];
            res_next.tex_v    = p1_itp_reg[1][rti_pkg::TEX_W-1:0];
            for (int i = 0; i < 3; i++) begin
                res_next.nrm[i] = p1_itp_reg[2+i];
                if (pt[i] < PT_LO)      res_next.pnt[i] = PT_LO[CW-1:0];
                else if (pt[i] > PT_HI) res_next.pnt[i] = PT_HI[CW-1:0];
                else                    res_next.pnt[i] = pt[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) res_reg <= res_next;
    end

    // ---------------- valid chain and output skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (ce) vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
            if (!m_tvalid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    m_tvalid_reg   <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_tvalid_reg   <= vld_reg[NSTG-1];
                end
            end else if (vld_reg[NSTG-1] && ce) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) skid_reg <= res_reg;
        if (!m_tvalid_reg || m_tready) out_reg <= skid_valid_reg ? skid_reg : res_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {2'b00, out_reg.pnt, out_reg.nrm, out_reg.tex_v,
                       out_reg.tex_u, out_reg.distance};

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss beat carries nonzero data");

    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ($signed(m_tdata[31:0]) > 0
                                   && m_tdata[31:0] != rti_pkg::DIST_MAX))
        else $error("hit with out-of-range distance");

endmodule

// ===== sim/ray_triangle_intersect_core_test.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core_test: self-checking bench for the ray/triangle core
// Loads several triangles through the config channel, streams directed and
// random rays, predicts each result in exact wide integer arithmetic and
// compares the hit flag and data word of every result beat, with random gaps and stalls.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core_test;

    typedef struct packed {
        logic                  hit;
        logic [191:0]          data;
    } hit_rec_t;

    typedef logic signed [159:0] wint_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_addr = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic         m_tuser;

    ray_triangle_intersect_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // triangle registers as seen by the predictor
    logic [63:0] tri_regs [0:7];

    logic [191:0] ray_queue [$];
    hit_rec_t     hit_queue [$];
    int           errors = 0;
    int           cycles = 0;
    int           hold_off = 0;   // receiver long stall counter
    bit           long_stall_req = 1'b0;
    bit           long_stall_done = 1'b0;
    bit           pause_rays = 1'b0;
    bit           drive_done = 1'b0;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------
    function automatic logic signed [63:0] fld(logic [63:0] r, int lsb, int w);
        logic signed [63:0] v;
        v = $signed(r >> lsb) <<< (64 - w);
        return v >>> (64 - w);
    endfunction

    function automatic wint_t sat_to(wint_t x, int w);
        wint_t lo, hi;
        lo = -(wint_t'(1) <<< (w - 1));
        hi = (wint_t'(1) <<< (w - 1)) - 1;
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // interpolate one attribute over the barycentric weights, truncated and saturated
    function automatic wint_t blend(wint_t wa, wint_t nu, wint_t nv, wint_t det,
                                    wint_t pa, wint_t pb, wint_t pc, int w);
        return sat_to((wa * pa + nu * pb + nv * pc) / det, w);
    endfunction

    function automatic hit_rec_t trace_ray(logic [191:0] ray);
        wint_t a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
        wint_t det, nu, nv, nt, wa, tq, tmin, tmax, p;
        hit_rec_t r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = fld(tri_regs[rti_pkg::REG_VA_POS], 21 * i, 21);
            b[i] = fld(tri_regs[rti_pkg::REG_VB_POS], 21 * i, 21);
            c[i] = fld(tri_regs[rti_pkg::REG_VC_POS], 21 * i, 21);
            o[i] = fld(64'(ray >> (21 * i)), 0, 21);
            d[i] = fld(64'(ray >> (63 + 21 * i)), 0, 21);
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            s[i] = o[i] - a[i];
        end
        tmin = fld(64'(ray >> 126), 0, 32);
        tmax = fld(64'(ray >> 158), 0, 32);
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        if (det == 0) return r;   // parallel ray
        nu = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        nv = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0) begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt <= 0) return r;
        tq = (nt <<< 16) / det;
        if (tq > 32'sh7FFF_FFFF) tq = 32'sh7FFF_FFFF;
        if (!(tq > 0 && tq > tmin && tq < tmax)) return r;
        wa = det - nu - nv;
        r.hit = 1'b1;
        r.data[31:0] = tq[31:0];
        r.data[47:32] = 16'(blend(wa, nu, nv, det,
            fld(tri_regs[rti_pkg::REG_TC_AB], 0, 16),
            fld(tri_regs[rti_pkg::REG_TC_AB], 32, 16),
            fld(tri_regs[rti_pkg::REG_TC_C], 0, 16), 16));
        r.data[63:48] = 16'(blend(wa, nu, nv, det,
            fld(tri_regs[rti_pkg::REG_TC_AB], 16, 16),
            fld(tri_regs[rti_pkg::REG_TC_AB], 48, 16),
            fld(tri_regs[rti_pkg::REG_TC_C], 16, 16), 16));
        for (int i = 0; i < 3; i++) begin
            r.data[64 + 21 * i +: 21] = 21'(blend(wa, nu, nv, det,
                fld(tri_regs[rti_pkg::REG_VA_NRM], 21 * i, 21),
                fld(tri_regs[rti_pkg::REG_VB_NRM], 21 * i, 21),
                fld(tri_regs[rti_pkg::REG_VC_NRM], 21 * i, 21), 21));
            p = o[i] + (tq * d[i]) / (wint_t'(1) <<< 16);
            r.data[127 + 21 * i +: 21] = 21'(sat_to(p, 21));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [191:0] pack_ray(logic [20:0] ox, logic [20:0] oy,
            logic [20:0] oz, logic [20:0] dx, logic [20:0] dy, logic [20:0] dz,
            logic [31:0] tmin, logic [31:0] tmax);
        return {2'b00, tmax, tmin, dz, dy, dx, oz, oy, ox};
    endfunction

    function automatic logic [20:0] rnd21();
        case ($urandom_range(0, 5))
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'($signed($urandom_range(0, 8191)) - 4096);
            default: return 21'($urandom);
        endcase
    endfunction

    // aim a ray from a random origin at a random point of the triangle
    function automatic logic [191:0] aimed_ray();
        int o[3], tgt[3], ua, ub;
        ua = $urandom_range(0, 1000);
        ub = $urandom_range(0, 1000 - ua);
        for (int i = 0; i < 3; i++) begin
            tgt[i] = (int'(fld(tri_regs[rti_pkg::REG_VA_POS], 21 * i, 21)) * (1000 - ua - ub)
                    + int'(fld(tri_regs[rti_pkg::REG_VB_POS], 21 * i, 21)) * ua
                    + int'(fld(tri_regs[rti_pkg::REG_VC_POS], 21 * i, 21)) * ub) / 1000;
            o[i] = $signed($urandom_range(0, 40000)) - 20000;
        end
        return pack_ray(21'(o[0]), 21'(o[1]), 21'(o[2]),
            21'(tgt[0] - o[0]), 21'(tgt[1] - o[1]), 21'(tgt[2] - o[2]),
            ($urandom_range(0, 3) == 0) ? $urandom : 32'h8000_0000,
            ($urandom_range(0, 3) == 0) ? $urandom : 32'h7FFF_FFFF);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tri_regs[idx] = (idx == rti_pkg::REG_TC_AB) ? val
                      : (idx == rti_pkg::REG_TC_C) ? {32'd0, val[31:0]}
                      : {1'b0, val[62:0]};
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_triangle(int mode);
        for (int i = 0; i < 8; i++) begin
            logic [63:0] v;
            v = {$urandom, $urandom};
            if (mode == 0) v = '0;
            else if (mode == 1) v = '1;
            else if (mode == 2 && i < 3)    // modest triangle in reach of rays
                v = {1'b0, 21'($signed($urandom_range(0, 16000)) - 8000),
                     21'($signed($urandom_range(0, 16000)) - 8000),
                     21'($signed($urandom_range(0, 16000)) - 8000)};
            write_reg(3'(i), v);
        end
    endtask

    task automatic wait_drained();
        while (!(ray_queue.size() == 0 && !s_tvalid && hit_queue.size() == 0))
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic run_phase(int n, bit directed);
        if (directed) begin
            logic [20:0] mx, mn;
            mx = 21'h0FFFFF; mn = 21'h100000;
            ray_queue.push_back(pack_ray(mx, mx, mx, mn, mn, mn, 32'h8000_0000, 32'h7FFF_FFFF));
            ray_queue.push_back(pack_ray(mn, mn, mn, mx, mx, mx, 32'h7FFF_FFFF, 32'h8000_0000));
            ray_queue.push_back(pack_ray('0, '0, '0, '0, '0, '0, '0, '0));
            for (int i = 0; i < 6; i++) ray_queue.push_back(aimed_ray());
            for (int i = 0; i < 4; i++) begin   // t_min above t_max always misses
                logic [191:0] r;
                r = aimed_ray();
                r[189:126] = {32'h0000_0001, 32'h0000_0002};
                ray_queue.push_back(r);
            end
        end
        for (int i = 0; i < n; i++)
            ray_queue.push_back(($urandom_range(0, 3) != 0) ? aimed_ray()
                : pack_ray(rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), rnd21(),
                           $urandom, $urandom));
        wait_drained();
    endtask

    // handshake sampled at the rising edge and registered for the driver, which acts at the falling edge
    logic s_tready_q = 1'b0;
    always @(posedge aclk) begin
        s_tready_q <= s_tready;
        if (aresetn && s_tvalid && s_tready) hit_queue.push_back(trace_ray(s_tdata));
    end

    // ---------------------------------------------------------------------
    // ray driver: changes inputs at the falling edge
    // ---------------------------------------------------------------------
    int gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready_q) begin
                // beat taken at the last rising edge
                if (gap == 0 && !pause_rays && ray_queue.size() > 0) begin
                    s_tdata <= ray_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (gap > 0) gap <= gap - 1;
                else if (!pause_rays && ray_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= ray_queue.pop_front();
                    gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30)
                         : ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result hit=%0b data=%h", $time, m_tuser, m_tdata);
                errors = errors + 1;
            end else begin
                hit_rec_t want;
                want = hit_queue.pop_front();
                if (want.hit !== m_tuser) begin
                    $display("%0t: hit exp %0b got %0b", $time, want.hit, m_tuser);
                    errors = errors + 1;
                end
                if (want.data !== m_tdata) begin
                    $display("%0t: data exp %h got %h", $time, want.data, m_tdata);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            hold_off        <= 300;
            long_stall_done <= 1'b1;
            m_tready        <= 1'b0;
        end else if ($urandom_range(0, 99) == 0) begin
            hold_off <= $urandom_range(20, 60);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || drive_done;
        end
    end

    // cycle limit: ~750 rays, each allowed its pipeline latency, a receiver stall and a sender gap, with margin
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 8; i++) tri_regs[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_phase(10, 1'b0);            // reset triangle: all parallel
        load_triangle(1);               // all ones
        run_phase(20, 1'b1);
        load_triangle(3);               // fully random registers
        run_phase(60, 1'b0);
        load_triangle(2);
        run_phase(150, 1'b1);

        // long receiver stall while rays keep coming: pipeline fills
        for (int i = 0; i < 80; i++) ray_queue.push_back(aimed_ray());
        long_stall_req = 1'b1;
        wait_drained();

        // sender pauses until every result is back, then resumes
        load_triangle(2);
        for (int i = 0; i < 200; i++) ray_queue.push_back(aimed_ray());
        repeat (100) @(posedge aclk);
        pause_rays = 1'b1;
        while (hit_queue.size() != 0) @(posedge aclk);
        pause_rays = 1'b0;
        wait_drained();

        load_triangle(2);
        run_phase(200, 1'b0);
        load_triangle(0);
        run_phase(10, 1'b0);

        drive_done = 1'b1;
        repeat (100) @(posedge aclk);
        if (errors == 0 && hit_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (hit_queue.size() != 0)
                $display("%0t: %0d results never came", $time, hit_queue.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
